// File: src/nfcrc_pkg.sv
// shared types and constants of the response frame checker
`default_nettype none

package nfcrc_pkg;

   // input opcodes
   localparam logic [1:0] OP_STATUS = 2'd0;
   localparam logic [1:0] OP_FRAME  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_NOSPACE = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_EXPECTED_COMMAND = 2'd0;
   localparam logic [1:0] CSR_MAX_PAYLOAD      = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_MS       = 2'd2;

   localparam logic [7:0]  EXPECTED_COMMAND_RESET = 8'd0;
   localparam logic [7:0]  MAX_PAYLOAD_RESET      = 8'd255;
   localparam logic [15:0] TIMEOUT_MS_RESET       = 16'd1000;

   // frame constants
   localparam logic [7:0]  PREAMBLE_BYTE = 8'h00;
   localparam logic [7:0]  START_BYTE    = 8'hFF;
   localparam logic [7:0]  TFI_TO_HOST   = 8'hD5;
   localparam logic [7:0]  LEN_OVERHEAD  = 8'd2;
   localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

   // queue between the front and back parts
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_FRAME  = 2'd1,
      KIND_TICK   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [7:0]  expected_command;
      logic [7:0]  max_payload;
      logic [15:0] timeout_ms;
   } cfg_type;

   typedef enum logic [9:0] {
      PH_WAIT  = 10'b00_0000_0001,
      PH_PRE0  = 10'b00_0000_0010,
      PH_PRE1  = 10'b00_0000_0100,
      PH_START = 10'b00_0000_1000,
      PH_LEN   = 10'b00_0001_0000,
      PH_LCS   = 10'b00_0010_0000,
      PH_TFI   = 10'b00_0100_0000,
      PH_CMD   = 10'b00_1000_0000,
      PH_DATA  = 10'b01_0000_0000,
      PH_DCS   = 10'b10_0000_0000
   } phase_type;

endpackage

`default_nettype wire

// File: src/nfcrc_front.sv
// front part: classifies incoming items and drops the ones that do nothing
`default_nettype none

module nfcrc_front (
   input  wire logic [1:0]        req_opcode,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   output nfcrc_pkg::item_type    item,
   output logic                   push
);
   import nfcrc_pkg::*;

   logic keep;

   always_comb begin
      item.data = req_data_byte;
      item.kind = KIND_FRAME;
      keep      = 1'b1;
      case (req_opcode)
         OP_STATUS: item.kind = KIND_STATUS;
         OP_FRAME:  item.kind = KIND_FRAME;
         OP_TICK:   item.kind = KIND_TICK;
         default:   keep      = 1'b0;   // unused opcode
      endcase
   end

   assign push = req_valid && !req_stall && keep;

endmodule

`default_nettype wire

// File: src/nfcrc_queue.sv
// short queue of classified items between the front and back parts
`default_nettype none

module nfcrc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  nfcrc_pkg::item_type      push_item,
   input  wire logic                pop,
   output nfcrc_pkg::item_type      head_item,
   output logic                     not_empty,
   output logic                     full
);
   import nfcrc_pkg::*;

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: src/nfcrc_back.sv
// back part: frame state machine and result register
`default_nettype none

module nfcrc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  nfcrc_pkg::cfg_type     cfg,
   input  nfcrc_pkg::item_type    item,
   input  wire logic              item_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_is_final,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_payload_length
);
   import nfcrc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [15:0] elapsed_ff, elapsed_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  payload_byte_ff, payload_byte_in;
   logic        is_final_ff, is_final_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  payload_length_ff, payload_length_in;

   logic        advance;
   logic        produce;
   logic        finish;
   logic [7:0]  cmd;
   logic [7:0]  payload_count;
   logic [7:0]  res_byte;
   logic [1:0]  res_status;
   logic [7:0]  res_length;

   assign advance       = !rsp_valid_ff || !rsp_stall;
   assign pop           = item_valid && advance;
   assign cmd           = cfg.expected_command + 8'd1;
   assign payload_count = frame_length_ff - LEN_OVERHEAD;

   always_comb begin
      phase_in        = phase_ff;
      remaining_in    = remaining_ff;
      frame_length_in = frame_length_ff;
      running_sum_in  = running_sum_ff;
      elapsed_in      = elapsed_ff;
      produce         = 1'b0;
      finish          = 1'b0;
      res_byte        = '0;
      res_status      = ST_OK;
      res_length      = '0;

      if (pop) begin
         case (item.kind)
            KIND_STATUS: begin
               remaining_in    = '0;
               frame_length_in = '0;
               running_sum_in  = '0;
               phase_in        = item.data[0] ? PH_PRE0 : PH_WAIT;
            end
            KIND_TICK: begin
               if (phase_ff == PH_WAIT) begin
                  if (cfg.timeout_ms != '0 && elapsed_ff >= cfg.timeout_ms) begin
                     finish     = 1'b1;
                     res_status = ST_TIMEOUT;
                  end else if (elapsed_ff != ELAPSED_MAX) begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
               end
            end
            KIND_FRAME: begin
               case (phase_ff)
                  PH_WAIT: ;
                  PH_PRE0: begin
                     if (item.data != PREAMBLE_BYTE) begin
                        finish     = 1'b1;
                        res_status = ST_INVALID;
                     end else begin
                        phase_in = PH_PRE1;
                     end
                  end
                  PH_PRE1: begin
                     if (item.data != PREAMBLE_BYTE) begin
                        finish     = 1'b1;
                        res_status = ST_INVALID;
                     end else begin
                        phase_in = PH_START;
                     end
                  end
                  PH_START: begin
                     if (item.data != START_BYTE) begin
                        finish     = 1'b1;
                        res_status = ST_INVALID;
                     end else begin
                        phase_in = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     frame_length_in = item.data;
                     phase_in        = PH_LCS;
                  end
                  PH_LCS: begin
                     if (frame_length_ff + item.data != 8'd0) begin
                        finish     = 1'b1;
                        res_status = ST_INVALID;
                     end else begin
                        phase_in = PH_TFI;
                     end
                  end
                  PH_TFI: begin
                     if (item.data != TFI_TO_HOST) begin
                        finish     = 1'b1;
                        res_status = ST_INVALID;
                     end else begin
                        phase_in = PH_CMD;
                     end
                  end
                  PH_CMD: begin
                     // command echo, then short length, then capacity
                     if (item.data != cmd || frame_length_ff < LEN_OVERHEAD) begin
                        finish     = 1'b1;
                        res_status = ST_INVALID;
                     end else if (payload_count > cfg.max_payload) begin
                        finish     = 1'b1;
                        res_status = ST_NOSPACE;
                     end else begin
                        remaining_in   = payload_count;
                        running_sum_in = TFI_TO_HOST + cmd;
                        phase_in       = (payload_count == '0) ? PH_DCS : PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     running_sum_in = running_sum_ff + item.data;
                     remaining_in   = remaining_ff - 8'd1;
                     if (remaining_ff == 8'd1) begin
                        phase_in = PH_DCS;
                     end
                     produce  = 1'b1;
                     res_byte = item.data;
                  end
                  PH_DCS: begin
                     finish = 1'b1;
                     if (running_sum_ff + item.data != 8'd0) begin
                        res_status = ST_INVALID;
                     end else begin
                        res_status = ST_OK;
                        res_length = payload_count;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      if (finish) begin
         produce         = 1'b1;
         phase_in        = PH_WAIT;
         remaining_in    = '0;
         frame_length_in = '0;
         running_sum_in  = '0;
         elapsed_in      = '0;
      end

      // result register holds while stalled
      if (advance) begin
         rsp_valid_in      = pop && produce;
         payload_byte_in   = res_byte;
         is_final_in       = finish;
         status_in         = res_status;
         payload_length_in = res_length;
      end else begin
         rsp_valid_in      = rsp_valid_ff;
         payload_byte_in   = payload_byte_ff;
         is_final_in       = is_final_ff;
         status_in         = status_ff;
         payload_length_in = payload_length_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WAIT;
         remaining_ff    <= '0;
         frame_length_ff <= '0;
         running_sum_ff  <= '0;
         elapsed_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         remaining_ff    <= remaining_in;
         frame_length_ff <= frame_length_in;
         running_sum_ff  <= running_sum_in;
         elapsed_ff      <= elapsed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_byte_ff   <= payload_byte_in;
      is_final_ff       <= is_final_in;
      status_ff         <= status_in;
      payload_length_ff <= payload_length_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = payload_byte_ff;
   assign rsp_is_final       = is_final_ff;
   assign rsp_status         = status_ff;
   assign rsp_payload_length = payload_length_ff;

endmodule

`default_nettype wire

// File: src/nfc_response_frame_checker_unit.sv
// top level of the response frame checker
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  opcode, data_byte
//   rsp_      out         rsp_valid / rsp_stall  payload_byte, is_final, status, payload_length
//   csr_      in          csr_write_enable       index, write_data
//
// one item per cycle sustained while rsp_stall does not hold the result register; the front
// classify stage is combinational and writes each item into the queue, from whose head the
// frame state machine takes it and loads its result into the result register
// a two-item queue parts the front from the back, so req_stall rises only when the
// queue is full, which comes about only while rsp_stall holds the result register
// synchronous active-high reset clears the queue, the frame state and the result valid,
// and loads the register reset values; no clearing pass is needed
`default_nettype none

module nfc_response_frame_checker_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input item channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_data_byte,
   // result item channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_is_final,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_payload_length,
   // register write port
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import nfcrc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type front_item;
   item_type head_item;
   logic     push;
   logic     pop;
   logic     not_empty;
   logic     full;

   // register writes; an unknown index is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPECTED_COMMAND: cfg_in.expected_command = csr_write_data[7:0];
            CSR_MAX_PAYLOAD:      cfg_in.max_payload      = csr_write_data[7:0];
            CSR_TIMEOUT_MS:       cfg_in.timeout_ms       = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_command <= EXPECTED_COMMAND_RESET;
         cfg_ff.max_payload      <= MAX_PAYLOAD_RESET;
         cfg_ff.timeout_ms       <= TIMEOUT_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stall depends only on queue fill, never on req_valid
   assign req_stall = full;

   // decode the opcode and drop unused codes
   nfcrc_front u_front (
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .item          (front_item),
      .push          (push)
   );

   // lets the front keep taking items while the back waits on rsp_stall
   nfcrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .not_empty (not_empty),
      .full      (full)
   );

   // frame checking, timeout counting and the result register
   nfcrc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .item               (head_item),
      .item_valid         (not_empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_is_final       (rsp_is_final),
      .rsp_status         (rsp_status),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule

`default_nettype wire

// File: src/nfcrc_checker.sv
// port-level checks of the response frame checker and their bind
`default_nettype none

module nfcrc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic       rsp_is_final,
   input wire logic [1:0] rsp_status,
   input wire logic [7:0] rsp_payload_length
);
   import nfcrc_pkg::*;

   // a held result keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_is_final) && $stable(rsp_status) && $stable(rsp_payload_length))
      else $error("held result changed");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // payload items carry ok status and no length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_final |-> rsp_status == ST_OK && rsp_payload_length == 8'd0)
      else $error("payload item with status or length");

   // final items carry no byte; only ok finals carry a length, at most 253
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_final |-> rsp_payload_byte == 8'd0
         && (rsp_status == ST_OK || rsp_payload_length == 8'd0)
         && rsp_payload_length <= 8'd253)
      else $error("bad final item fields");

endmodule

bind nfc_response_frame_checker_unit nfcrc_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_is_final       (rsp_is_final),
   .rsp_status         (rsp_status),
   .rsp_payload_length (rsp_payload_length)
);

`default_nettype wire
